>>> hw/rtl/salc_pkg.sv
// Shared types and constants of the set-associative LRU cache simulator.
// No dependencies; the front end, back end and top level import it.
package salc_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_OTHER  = 2'd3;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS_USED  = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  // One decoded request on its way from the front end to the back end.
  typedef struct packed {
    logic        active;   // load, store or modify
    logic        modify;   // two accesses
    logic [11:0] set_idx;  // wide enough for the largest set count
    logic [63:0] tag;
  } salc_cmd_t;

endpackage

>>> hw/rtl/salc_front.sv
// Front end: takes requests, splits the address into set index and tag,
// and pushes the decoded request into a small queue. Uses salc_pkg.
module salc_front #(
  parameter int MaxSetBits = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [63:0]          address_i,
  input  logic [2:0]           set_bits_i,
  input  logic [5:0]           block_bits_i,
  output salc_pkg::salc_cmd_t  cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i
);
  import salc_pkg::*;

  localparam int Depth = 2;

  salc_cmd_t   fifo_q [Depth];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  salc_cmd_t   dec;
  logic [3:0]  s_eff;
  logic [6:0]  tag_sh;
  logic [63:0] set_sh;
  logic [11:0] set_mask;
  logic        push, pop;

  always_comb begin
    s_eff = ({1'b0, set_bits_i} > 4'(MaxSetBits)) ? 4'(MaxSetBits) : {1'b0, set_bits_i};
    set_sh = address_i >> block_bits_i;
    tag_sh = 7'(block_bits_i) + 7'(s_eff);
    set_mask = 12'((13'd1 << s_eff) - 13'd1);
    dec.active = (req_type_i != REQ_OTHER);
    dec.modify = (req_type_i == REQ_MODIFY);
    dec.set_idx = set_sh[11:0] & set_mask;
    dec.tag = (tag_sh >= 7'd64) ? 64'd0 : (address_i >> tag_sh[5:0]);
  end

  assign in_ready_o  = (cnt_q != 2'(Depth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/salc_back.sv
// Back end: runs the cache accesses of one decoded request against the line
// memories and produces the result transaction. Uses salc_pkg.
module salc_back #(
  parameter int MaxSetBits = 6,
  parameter int MaxWays    = 8,
  parameter int StampWidth = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  salc_pkg::salc_cmd_t cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  logic [3:0]          ways_used_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [1:0]          hits_now_o,
  output logic                missed_now_o,
  output logic                evicted_now_o,
  output logic [31:0]         total_hits_o,
  output logic [31:0]         total_misses_o,
  output logic [31:0]         total_evictions_o
);
  import salc_pkg::*;

  localparam int Sets  = 1 << MaxSetBits;
  localparam int SW    = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int WW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int CW    = $clog2(MaxWays + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Valid bits, tags and stamps are per-set rows, all read in ST_READ.
  // The valid rows are cleared by a pass over every set after reset.
  logic [MaxWays-1:0]              valid_mem [Sets];
  logic [MaxWays-1:0][63:0]         tag_mem [Sets];
  logic [MaxWays-1:0][StampWidth-1:0] stamp_mem [Sets];
  logic [MaxWays-1:0]              valid_rd_q;
  logic [MaxWays-1:0][63:0]         tag_rd_q;
  logic [MaxWays-1:0][StampWidth-1:0] stamp_rd_q;

  logic [1:0]            state_q;
  logic                  second_q;
  logic                  clr_q;
  logic [SW-1:0]         clr_idx_q;
  salc_cmd_t             cmd_q;
  logic [StampWidth-1:0] clock_q;
  logic [31:0]           th_q, tm_q, te_q;
  logic [1:0]            hits_q;
  logic                  miss_q, evict_q;
  logic [SW-1:0]         set_a;
  logic [CW-1:0]         ways;
  logic [MaxWays-1:0]    vrow;
  logic                  hit, have_empty, do_write;
  logic [WW-1:0]         hit_way, empty_way, lru_way, victim;
  logic [StampWidth-1:0] stamp_new;

  assign set_a = cmd_q.set_idx[SW-1:0];
  assign vrow  = valid_rd_q;
  assign stamp_new = clock_q + 1'b1;

  always_comb begin
    if (ways_used_i == 4'd0) ways = CW'(1);
    else if ({28'd0, ways_used_i} > 32'(MaxWays)) ways = CW'(MaxWays);
    else ways = CW'(ways_used_i);
  end

  // Way search over at most MaxWays independent compares.
  always_comb begin
    logic [StampWidth-1:0] best;
    hit = 1'b0; hit_way = '0; have_empty = 1'b0; empty_way = '0;
    lru_way = '0; best = stamp_rd_q[0];
    for (int w = 0; w < MaxWays; w++) begin
      if (CW'(w) < ways) begin
        if (vrow[w] && tag_rd_q[w] == cmd_q.tag && !hit) begin
          hit = 1'b1; hit_way = WW'(w);
        end
        if (!vrow[w]) begin
          have_empty = 1'b1; empty_way = WW'(w);
        end
        if (w > 0 && stamp_rd_q[w] < best) begin
          best = stamp_rd_q[w]; lru_way = WW'(w);
        end
      end
    end
    victim = hit ? hit_way : (have_empty ? empty_way : lru_way);
  end

  assign do_write = (state_q == ST_EVAL);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      valid_rd_q <= valid_mem[set_a];
      tag_rd_q   <= tag_mem[set_a];
      stamp_rd_q <= stamp_mem[set_a];
    end
    if (clr_q) valid_mem[clr_idx_q] <= '0;
    if (do_write) begin
      stamp_mem[set_a][victim] <= stamp_new;
      if (!hit) begin
        tag_mem[set_a][victim]   <= cmd_q.tag;
        valid_mem[set_a][victim] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == SW'(Sets - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; second_q <= 1'b0; clock_q <= '0;
      th_q <= '0; tm_q <= '0; te_q <= '0;
      hits_q <= '0; miss_q <= 1'b0; evict_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && !clr_q) begin
            hits_q <= '0; miss_q <= 1'b0; evict_q <= 1'b0; second_q <= 1'b0;
            state_q <= cmd_i.active ? ST_READ : ST_OUT;
          end
        end
        ST_READ: state_q <= ST_EVAL;
        ST_EVAL: begin
          clock_q <= stamp_new;
          if (hit) begin
            hits_q <= hits_q + 2'd1;
            if (th_q != '1) th_q <= th_q + 32'd1;
          end else begin
            miss_q <= 1'b1;
            if (tm_q != '1) tm_q <= tm_q + 32'd1;
            if (!have_empty) begin
              evict_q <= 1'b1;
              if (te_q != '1) te_q <= te_q + 32'd1;
            end
          end
          if (cmd_q.modify && !second_q) begin
            second_q <= 1'b1; state_q <= ST_READ;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: if (res_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cmd_ready_o       = (state_q == ST_IDLE) && !clr_q;
  assign res_valid_o       = (state_q == ST_OUT);
  assign hits_now_o        = hits_q;
  assign missed_now_o      = miss_q;
  assign evicted_now_o     = evict_q;
  assign total_hits_o      = th_q;
  assign total_misses_o    = tm_q;
  assign total_evictions_o = te_q;

endmodule

>>> hw/rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache simulator: APB register file,
// front end, back end. Depends on salc_pkg, salc_front and salc_back.
//
// Each request transaction on the slave stream is one load, store or modify
// to a 64-bit address; each produces exactly one result transaction with this
// request's hit, miss and eviction flags and the saturating totals. A load or
// store passes through the back end in order: take the request, read the set
// row, compare ways and update, present the result and hold it until taken.
// A modify reads, compares and updates twice for its two dependent accesses;
// an ignored request type goes straight to presenting its result. A two-entry
// queue after the address decode lets new requests be taken while the back end
// works. After reset the back end clears the valid bits in a pass over every
// set before it takes its first request; the queue can still take two requests
// meanwhile. Registers: set_bits at 0x0, ways_used at 0x4, block_bits at 0x8;
// write them only while the block is idle.
module set_assoc_lru_cache_sim #(
  parameter int MaxSetBits = 6,
  parameter int MaxWays    = 8,
  parameter int StampWidth = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // address
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // hits_now, missed_now, evicted_now,
                                      // total_hits, total_misses,
                                      // total_evictions, zero fill
);
  import salc_pkg::*;

  logic [2:0] set_bits_q;
  logic [3:0] ways_used_q;
  logic [5:0] block_bits_q;
  salc_cmd_t  cmd;
  logic       cmd_valid, cmd_ready;
  logic [1:0]  hits_now;
  logic        missed_now, evicted_now;
  logic [31:0] total_hits, total_misses, total_evictions;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd4; ways_used_q <= 4'd1; block_bits_q <= 6'd4;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SET_BITS:   set_bits_q   <= pwdata[2:0];
        REG_WAYS_USED:  ways_used_q  <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, set_bits_q};
      REG_WAYS_USED:  prdata = {28'd0, ways_used_q};
      REG_BLOCK_BITS: prdata = {26'd0, block_bits_q};
      default:        prdata = 32'd0;
    endcase
  end

  salc_front #(.MaxSetBits(MaxSetBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .req_type_i(s_axis_tuser), .address_i(s_axis_tdata),
    .set_bits_i(set_bits_q), .block_bits_i(block_bits_q),
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  salc_back #(.MaxSetBits(MaxSetBits), .MaxWays(MaxWays), .StampWidth(StampWidth)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .ways_used_i(ways_used_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .hits_now_o(hits_now), .missed_now_o(missed_now), .evicted_now_o(evicted_now),
    .total_hits_o(total_hits), .total_misses_o(total_misses),
    .total_evictions_o(total_evictions)
  );

  assign m_axis_tdata = {4'd0, total_evictions, total_misses, total_hits,
                         evicted_now, missed_now, hits_now};

endmodule

>>> hw/rtl/salc_checker.sv
// Port-level checks of the cache simulator's result stream.
// Depends only on the top level's ports; bound to set_assoc_lru_cache_sim.
module salc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  // A single request never both hits twice and misses.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1:0] == 2'd2 && m_axis_tdata[2]))
    else $error("two hits together with a miss");
  // An eviction only comes with a miss.
  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
    else $error("eviction without miss");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule

bind set_assoc_lru_cache_sim salc_checker u_checker (.*);
